### hw/rtl/base64_stream_encoder_unit_defines.svh
// assertion macros for the base64 stream encoder unit
`ifndef BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define B64E_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define B64E_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/b64e_pkg.sv
// shared types, constants and character lookup for the base64 stream encoder
package b64e_pkg;

    localparam int CHAR_W      = 7;
    localparam int MAX_CHARS   = 4;
    localparam int IDX_W       = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]                 last_idx;
        logic                             fin;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [CHAR_W-1:0] enc_char(input logic [5:0] sextet);
        logic [CHAR_W-1:0] s;
        logic [CHAR_W-1:0] c;
        s = {1'b0, sextet};
        if (sextet < 6'd26) begin
            c = s + 7'd65;
        end else if (sextet < 6'd52) begin
            c = s + 7'd71;
        end else if (sextet < 6'd62) begin
            c = s - 7'd4;
        end else if (sextet == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

### hw/rtl/base64_stream_encoder_unit.sv
// top level of the base64 stream encoder
// path: a byte's command is written into the queue, then its characters enter the output register
// throughput: one character per cycle unless stalled; 1, 1 or 2 chars per byte by phase
// a final byte yields 2 to 4 characters with flush and padding, all through the single output port
// the two-entry command queue takes bytes while the output register is stalled
// reset: synchronous active low, clears group phase, leftover bits, queue and output valid
`include "base64_stream_encoder_unit_defines.svh"

module base64_stream_encoder_unit #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_final_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [b64e_pkg::CHAR_W-1:0]     o_out_char,
    output logic                            o_run_end,
    output logic                            o_stream_end
);

    logic               w_push;
    logic               w_pop;
    b64e_pkg::t_cmd     w_cmd;
    b64e_pkg::t_cmd     w_head;
    b64e_pkg::t_q_stat  w_q_stat;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_q_stat     (w_q_stat),
        .o_in_stall   (o_in_stall),
        .o_push       (w_push),
        .o_cmd        (w_cmd)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_char   (o_out_char),
        .o_run_end    (o_run_end),
        .o_stream_end (o_stream_end)
    );

    `B64E_ASSERT(a_push_not_full, i_clk, i_rst_n, !w_push || !w_q_stat.full, "push into full queue")
    `B64E_ASSERT(a_pop_not_empty, i_clk, i_rst_n, !w_pop || !w_q_stat.empty, "pop from empty queue")
    `B64E_ASSERT(a_stream_end_run_end, i_clk, i_rst_n, !(o_out_valid && o_stream_end) || o_run_end, "stream end without run end")
    `B64E_ASSERT_NEXT(a_pop_shows_run_end, i_clk, i_rst_n, w_pop, o_out_valid && o_run_end, "popped command did not end a run")

endmodule

### hw/rtl/b64e_front.sv
// front end: accepts bytes, tracks group phase and builds character commands
module b64e_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [7:0]          i_data_byte,
    input  logic                i_final_byte,
    input  b64e_pkg::t_q_stat   i_q_stat,
    output logic                o_in_stall,
    output logic                o_push,
    output b64e_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        PH0,
        PH1,
        PH2
    } t_phase;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [3:0]  r_left;
    logic [3:0]  n_left;

    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    always_comb begin
        o_cmd.fin      = i_final_byte;
        o_cmd.chars[0] = b64e_pkg::enc_char(i_data_byte[7:2]);
        o_cmd.chars[1] = b64e_pkg::enc_char({i_data_byte[1:0], 4'b0000});
        o_cmd.chars[2] = b64e_pkg::PAD_CHAR;
        o_cmd.chars[3] = b64e_pkg::PAD_CHAR;
        o_cmd.last_idx = i_final_byte ? 2'd3 : 2'd0;
        n_left         = {2'b00, i_data_byte[1:0]};
        n_phase        = PH1;
        unique case (r_phase)
            PH1: begin
                o_cmd.chars[0] = b64e_pkg::enc_char({r_left[1:0], i_data_byte[7:4]});
                o_cmd.chars[1] = b64e_pkg::enc_char({i_data_byte[3:0], 2'b00});
                o_cmd.last_idx = i_final_byte ? 2'd2 : 2'd0;
                n_left         = i_data_byte[3:0];
                n_phase        = PH2;
            end
            PH2: begin
                o_cmd.chars[0] = b64e_pkg::enc_char({r_left, i_data_byte[7:6]});
                o_cmd.chars[1] = b64e_pkg::enc_char(i_data_byte[5:0]);
                o_cmd.last_idx = 2'd1;
                n_left         = 4'd0;
                n_phase        = PH0;
            end
            default: begin
            end
        endcase
        if (i_final_byte) begin
            n_left  = 4'd0;
            n_phase = PH0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH0;
            r_left  <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

### hw/rtl/b64e_queue.sv
// short command queue between front end and back end
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64e_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output b64e_pkg::t_cmd      o_head,
    output b64e_pkg::t_q_stat   o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/b64e_back.sv
// back end: emits the characters of each command one word per cycle while the output is not stalled
module b64e_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  b64e_pkg::t_cmd                  i_head,
    input  b64e_pkg::t_q_stat               i_q_stat,
    output logic                            o_pop,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [b64e_pkg::CHAR_W-1:0]     o_out_char,
    output logic                            o_run_end,
    output logic                            o_stream_end
);

    logic                       r_out_valid;
    logic [b64e_pkg::CHAR_W-1:0] r_out_char;
    logic                       r_run_end;
    logic                       r_stream_end;
    logic [b64e_pkg::IDX_W-1:0] r_idx;
    logic                       slot_free;
    logic                       load;
    logic                       last;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign load      = slot_free && !i_q_stat.empty;
    assign last      = (r_idx == i_head.last_idx);
    assign o_pop     = load && last;

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_run_end    = r_run_end;
    assign o_stream_end = r_stream_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_idx       <= last ? '0 : r_idx + 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char   <= i_head.chars[r_idx];
            r_run_end    <= last;
            r_stream_end <= last && i_head.fin;
        end
    end

endmodule

### tb/tb_top.sv
// self-checking testbench for the base64 stream encoder unit
module tb_top;

    typedef struct packed {
        logic [b64e_pkg::CHAR_W-1:0] ch;
        logic                        run_end;
        logic                        stream_end;
    } t_char_word;

    typedef struct {
        logic [7:0] data;
        logic       fin;
        string      chars;
    } t_dir_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [7:0]                  i_data_byte;
    logic                        i_final_byte;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [b64e_pkg::CHAR_W-1:0] o_out_char;
    logic                        o_run_end;
    logic                        o_stream_end;

    logic [1:0]  b64_phase;
    logic [3:0]  b64_left;
    t_char_word  step_chars[$];
    t_char_word  exp_chars[$];
    t_dir_row    dir_rows[$];

    int err_count = 0;
    int bytes_sent = 0;
    int chars_seen = 0;
    int msgs_seen = 0;
    int long_holds = 0;
    int tx_calm = 0;
    bit long_hold_req = 1'b0;

    base64_stream_encoder_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_run_end    (o_run_end),
        .o_stream_end (o_stream_end)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [b64e_pkg::CHAR_W-1:0] sextet_char(input logic [5:0] s);
        string alpha;
        byte   c;
        alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        c = alpha[s];
        return c[b64e_pkg::CHAR_W-1:0];
    endfunction

    function automatic int draw_idle(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // characters one byte yields, and the group state it leaves
    task automatic encode_word(input logic [7:0] b, input logic fin);
        t_char_word last;
        step_chars.delete();
        case (b64_phase)
            2'd1: begin
                step_chars.push_back('{sextet_char({b64_left[1:0], b[7:4]}), 1'b0, 1'b0});
                if (fin) begin
                    step_chars.push_back('{sextet_char({b[3:0], 2'b00}), 1'b0, 1'b0});
                    step_chars.push_back('{b64e_pkg::PAD_CHAR, 1'b0, 1'b0});
                end
                b64_left  = b[3:0];
                b64_phase = 2'd2;
            end
            2'd2: begin
                step_chars.push_back('{sextet_char({b64_left, b[7:6]}), 1'b0, 1'b0});
                step_chars.push_back('{sextet_char(b[5:0]), 1'b0, 1'b0});
                b64_left  = 4'd0;
                b64_phase = 2'd0;
            end
            default: begin
                step_chars.push_back('{sextet_char(b[7:2]), 1'b0, 1'b0});
                if (fin) begin
                    step_chars.push_back('{sextet_char({b[1:0], 4'b0000}), 1'b0, 1'b0});
                    step_chars.push_back('{b64e_pkg::PAD_CHAR, 1'b0, 1'b0});
                    step_chars.push_back('{b64e_pkg::PAD_CHAR, 1'b0, 1'b0});
                end
                b64_left  = {2'b00, b[1:0]};
                b64_phase = 2'd1;
            end
        endcase
        last = step_chars.pop_back();
        last.run_end    = 1'b1;
        last.stream_end = fin;
        step_chars.push_back(last);
        if (fin) begin
            b64_phase = 2'd0;
            b64_left  = 4'd0;
        end
    endtask

    // offer one word and book what it must produce; typed chars override the predictor
    task automatic send_word(input logic [7:0] d, input logic fin, input string typed);
        int  gap;
        byte tc;
        gap = draw_idle(tx_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= d;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        encode_word(d, fin);
        if (typed.len() == 0) begin
            foreach (step_chars[k]) exp_chars.push_back(step_chars[k]);
        end else begin
            for (int k = 0; k < typed.len(); k++) begin
                tc = typed[k];
                exp_chars.push_back('{tc[b64e_pkg::CHAR_W-1:0], k == typed.len() - 1,
                                     fin && (k == typed.len() - 1)});
            end
        end
    endtask

    task automatic add_row(input logic [7:0] d, input logic fin, input string chars);
        dir_rows.push_back('{d, fin, chars});
    endtask

    initial begin : sender
        int len;
        int rand_bytes;
        bit drained;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= 8'h00;
        i_final_byte <= 1'b0;
        b64_phase = 2'd0;
        b64_left  = 4'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(8'h00, 1'b1, "AA==");
        add_row(8'hFF, 1'b1, "/w==");
        add_row(8'h4D, 1'b0, "T");
        add_row(8'h61, 1'b0, "W");
        add_row(8'h6E, 1'b0, "Fu");
        add_row(8'hFF, 1'b0, "/");
        add_row(8'hFF, 1'b0, "/");
        add_row(8'hFF, 1'b0, "//");
        add_row(8'h00, 1'b0, "A");
        add_row(8'h00, 1'b0, "A");
        add_row(8'h00, 1'b0, "AA");
        add_row(8'h4D, 1'b0, "T");
        add_row(8'h61, 1'b1, "WE=");
        add_row(8'hFF, 1'b0, "/");
        add_row(8'hFF, 1'b1, "/8=");
        add_row(8'h4D, 1'b0, "T");
        add_row(8'h61, 1'b0, "W");
        add_row(8'h6E, 1'b1, "Fu");
        add_row(8'h80, 1'b0, "");
        add_row(8'h01, 1'b0, "");
        add_row(8'h7F, 1'b0, "");
        add_row(8'hA5, 1'b1, "");
        add_row(8'h5A, 1'b0, "");
        add_row(8'hC3, 1'b1, "");
        foreach (dir_rows[r]) send_word(dir_rows[r].data, dir_rows[r].fin, dir_rows[r].chars);

        rand_bytes = 0;
        drained = 1'b0;
        while (rand_bytes < 400) begin
            case ($urandom_range(0, 7))
                0:       len = 1;
                1:       len = $urandom_range(20, 40);
                default: len = $urandom_range(2, 10);
            endcase
            if (!long_holds && rand_bytes > 100) long_hold_req = 1'b1;
            if (!drained && rand_bytes > 250) begin
                drained = 1'b1;
                i_in_valid <= 1'b0;
                while (exp_chars.size() != 0) @(posedge i_clk);
            end
            for (int k = 0; k < len; k++) begin
                send_word(8'($urandom_range(0, 255)), k == len - 1, "");
                rand_bytes++;
            end
        end
        i_in_valid <= 1'b0;

        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("%0d bytes sent, %0d messages closed, %0d characters checked",
                 bytes_sent, msgs_seen, chars_seen);
        $display("every group phase with and without flush, %0d long output hold-off(s)",
                 long_holds);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : receiver
        int hold;
        int calm;
        calm = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = draw_idle(calm);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                long_holds++;
                hold = 60;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : char_check
        t_char_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            chars_seen++;
            if (o_stream_end) msgs_seen++;
            if (exp_chars.size() == 0) begin
                $display("%0t: unexpected char %h run_end %b stream_end %b", $time,
                         o_out_char, o_run_end, o_stream_end);
                err_count++;
            end else begin
                want = exp_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    $display("%0t: out_char expected %h actual %h", $time, want.ch, o_out_char);
                    err_count++;
                end
                if (o_run_end !== want.run_end) begin
                    $display("%0t: run_end expected %b actual %b", $time, want.run_end,
                             o_run_end);
                    err_count++;
                end
                if (o_stream_end !== want.stream_end) begin
                    $display("%0t: stream_end expected %b actual %b", $time, want.stream_end,
                             o_stream_end);
                    err_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #2000000;
        $display("%0t: timeout with %0d chars outstanding", $time, exp_chars.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
